// File: design/assert_macros.svh
// Assertion macros shared by the tournament predictor RTL.
// Included by files that carry concurrent checks; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, switched off while reset is held.
`define ASSERT_CHK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check on every rising edge, also while reset is held.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/tbp_pkg.sv
// Shared types, constants and counter helpers of the tournament predictor.
// No dependencies; used by the front, back and top-level modules.
`timescale 1ns / 1ps

package tbp_pkg;

  localparam int unsigned HIST_W  = 11;
  localparam int unsigned CTR_W   = 2;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned PC_W    = 32;

  localparam logic [HIST_W-1:0]  HIST_MASK_RESET = 11'h7FF;
  localparam logic [CTR_W-1:0]   CTR_MAX         = 2'd3;
  localparam logic [CTR_W-1:0]   CTR_MIN         = 2'd0;
  // table reset values: both predictors strongly taken, chooser strongly gshare
  localparam logic [CTR_W-1:0]   PRED_RESET      = CTR_MAX;
  localparam logic [CTR_W-1:0]   CHOOSER_RESET   = CTR_MIN;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX       = 32'hFFFF_FFFF;

  // one result word
  typedef struct packed {
    logic               predicted_taken;
    logic               correct;
    logic               used_bimodal;
    logic [TOTAL_W-1:0] correct_count;
    logic [TOTAL_W-1:0] branch_count;
  } result_t;

  // saturating 2-bit counter step
  function automatic logic [CTR_W-1:0] sat_move(input logic [CTR_W-1:0] c, input logic up);
    logic [CTR_W-1:0] r;
    r = c;
    if (up) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

// File: design/tournament_branch_predictor.sv
// Top level of the tournament (gshare plus bimodal) branch predictor.
// Depends on tbp_pkg, tbp_front, tbp_queue and tbp_back.
`timescale 1ns / 1ps

// Takes one resolved branch word per clock while s_axis_tready is high and returns
// one result word for each, in order. After reset the three counter tables are swept
// to their start values, one entry a cycle, with s_axis_tready held low until the
// sweep is done; the history mask can be written during that time. Sustained rate is
// one branch per cycle while m_axis_tready stays high; each branch passes the queue
// and the execute stage before its result is held in the output register. The rate is
// set by the read-modify-write of each counter table through one read and
// one write port, with the entry just written passed straight to the branch
// behind it. A two-word queue between index forming and table update, and
// the output register, let input and output stall apart.
module tournament_branch_predictor #(
  parameter int unsigned TABLE_ENTRIES = 2048
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tbp_pkg::HIST_W-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [31:0] pc, [32] taken, [39:33] zero
  input  logic [39:0]                s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [0] predicted_taken, [1] correct, [2] used_bimodal,
  // [34:3] correct_count, [66:35] branch_count, [71:67] zero
  output logic [71:0]                m_axis_tdata
);

  localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int unsigned ITEM_W = 2 * IDX_W + 1;

  logic              accept;
  logic [ITEM_W-1:0] front_item, queue_item;
  logic              queue_full, queue_valid, queue_pop;
  logic              clearing;
  tbp_pkg::result_t  result;

  assign s_axis_tready = !clearing && !queue_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  tbp_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .pc_i        (s_axis_tdata[31:0]),
    .taken_i     (s_axis_tdata[32]),
    .item_o      (front_item)
  );

  tbp_queue #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .data_o  (queue_item)
  );

  tbp_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .pop_o        (queue_pop),
    .clearing_o   (clearing),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .result_o     (result)
  );

  assign m_axis_tdata = {5'd0, result.branch_count, result.correct_count,
                         result.used_bimodal, result.correct, result.predicted_taken};

endmodule

// File: design/tbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the predictor counter tables.
`timescale 1ns / 1ps

module tbp_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents when both ports hit one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/tbp_queue.sv
// Two-entry word queue between the predictor front and back parts.
// No dependencies.
`timescale 1ns / 1ps

module tbp_queue #(
  parameter int unsigned WIDTH = 23
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) wr_ptr_d = ~wr_ptr_q;
    if (pop_i)  rd_ptr_d = ~rd_ptr_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];

endmodule

// File: design/tbp_front.sv
// Front part: global history, history mask register and table index forming.
// Depends on tbp_pkg.
`timescale 1ns / 1ps

module tbp_front #(
  parameter int unsigned TABLE_ENTRIES = 2048,
  localparam int unsigned IDX_W        = $clog2(TABLE_ENTRIES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tbp_pkg::HIST_W-1:0]  cfg_wdata_i,
  input  logic                        accept_i,
  input  logic [tbp_pkg::PC_W-1:0]    pc_i,
  input  logic                        taken_i,
  // {taken, gshare index, bimodal index}
  output logic [2*IDX_W:0]            item_o
);

  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_ENTRIES - 1);

  logic [tbp_pkg::HIST_W-1:0] hist_q, hist_d;
  logic [tbp_pkg::HIST_W-1:0] mask_q;
  logic [31:0]                hist_ext;
  logic [IDX_W-1:0]           bi_idx;
  logic [IDX_W-1:0]           gs_idx;

  // history register: newest outcome enters at bit 0
  assign hist_d = accept_i ? {hist_q[tbp_pkg::HIST_W-2:0], taken_i} : hist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      mask_q <= tbp_pkg::HIST_MASK_RESET;
    end else begin
      hist_q <= hist_d;
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
    end
  end

  // index forming; history bits beyond the index width fall away
  assign hist_ext = 32'(hist_q & mask_q);
  assign bi_idx   = pc_i[IDX_W-1:0] & IDX_MASK;
  assign gs_idx   = (bi_idx ^ hist_ext[IDX_W-1:0]) & IDX_MASK;

  assign item_o = {taken_i, gs_idx, bi_idx};

endmodule

// File: design/tbp_back.sv
// Back part: counter tables, chooser update, totals and output register.
// Depends on tbp_pkg, tbp_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tbp_back #(
  parameter int unsigned TABLE_ENTRIES = 2048,
  localparam int unsigned IDX_W        = $clog2(TABLE_ENTRIES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  logic [2*IDX_W:0]    item_i,
  output logic                pop_o,
  output logic                clearing_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tbp_pkg::result_t    result_o
);

  localparam int unsigned CW = tbp_pkg::CTR_W;
  localparam logic        ST_CLEAR = 1'b0;
  localparam logic        ST_RUN   = 1'b1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // clearing sweep
  logic             state_q, state_d;
  logic [IDX_W-1:0] clr_idx_q, clr_idx_d;

  // incoming word
  logic [IDX_W-1:0] in_bi, in_gi;
  logic             in_taken;

  // execute stage
  logic             s2_valid_q, s2_valid_d;
  logic [IDX_W-1:0] s2_bi_q, s2_gi_q;
  logic             s2_taken_q;
  logic             fwd_bc_q, fwd_g_q;
  logic [2*CW-1:0]  fwd_bc_data_q;
  logic [CW-1:0]    fwd_g_data_q;
  logic             s2_fire, pop, out_free;

  // table ports
  logic             bc_we, g_we;
  logic [IDX_W-1:0] bc_waddr, g_waddr;
  logic [2*CW-1:0]  bc_wdata, bc_rdata, bc_cur, bc_new;
  logic [CW-1:0]    g_wdata, g_rdata, g_cur, g_new;

  // prediction and update
  logic          gpred, bpred, use_bi, pred, ok, g_ok, b_ok;
  logic [CW-1:0] ch_new, bim_new;

  // totals and output register
  logic [tbp_pkg::TOTAL_W-1:0] hits_q, hits_d, branches_q, branches_d;
  logic                        out_valid_q, out_valid_d;
  tbp_pkg::result_t            out_q;

  assign in_bi    = item_i[IDX_W-1:0];
  assign in_gi    = item_i[2*IDX_W-1:IDX_W];
  assign in_taken = item_i[2*IDX_W];

  // clearing sweep control
  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    if (state_q == ST_CLEAR) begin
      clr_idx_d = clr_idx_q + 1'b1;
      if (clr_idx_q == LAST_IDX) state_d = ST_RUN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  // stage handshakes
  assign out_free = !out_valid_q || out_ready_i;
  assign s2_fire  = s2_valid_q && out_free;
  assign pop      = item_valid_i && (state_q == ST_RUN) && (!s2_valid_q || s2_fire);

  // tables: bimodal in the low half, chooser in the high half of one word
  assign bc_we    = (state_q == ST_CLEAR) || s2_fire;
  assign bc_waddr = (state_q == ST_CLEAR) ? clr_idx_q : s2_bi_q;
  assign bc_wdata = (state_q == ST_CLEAR) ? {tbp_pkg::CHOOSER_RESET, tbp_pkg::PRED_RESET}
                                          : bc_new;
  assign g_we     = bc_we;
  assign g_waddr  = (state_q == ST_CLEAR) ? clr_idx_q : s2_gi_q;
  assign g_wdata  = (state_q == ST_CLEAR) ? tbp_pkg::PRED_RESET : g_new;

  tbp_ram #(
    .WIDTH (2*CW),
    .DEPTH (TABLE_ENTRIES)
  ) u_bc_ram (
    .clk_i   (clk_i),
    .we_i    (bc_we),
    .waddr_i (bc_waddr),
    .wdata_i (bc_wdata),
    .re_i    (pop),
    .raddr_i (in_bi),
    .rdata_o (bc_rdata)
  );

  tbp_ram #(
    .WIDTH (CW),
    .DEPTH (TABLE_ENTRIES)
  ) u_g_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .re_i    (pop),
    .raddr_i (in_gi),
    .rdata_o (g_rdata)
  );

  // current counters: take the write of the word ahead when it hit the same entry
  assign bc_cur = fwd_bc_q ? fwd_bc_data_q : bc_rdata;
  assign g_cur  = fwd_g_q  ? fwd_g_data_q  : g_rdata;

  assign gpred  = g_cur[CW-1];
  assign bpred  = bc_cur[CW-1];
  assign use_bi = bc_cur[2*CW-1];
  assign pred   = use_bi ? bpred : gpred;
  assign ok     = (pred == s2_taken_q);
  assign g_ok   = (gpred == s2_taken_q);
  assign b_ok   = (bpred == s2_taken_q);

  // chooser leans towards the table that alone was right
  always_comb begin
    ch_new = bc_cur[2*CW-1:CW];
    if (g_ok && !b_ok) begin
      ch_new = tbp_pkg::sat_move(bc_cur[2*CW-1:CW], 1'b0);
    end else if (b_ok && !g_ok) begin
      ch_new = tbp_pkg::sat_move(bc_cur[2*CW-1:CW], 1'b1);
    end
  end

  assign bim_new = tbp_pkg::sat_move(bc_cur[CW-1:0], s2_taken_q);
  assign bc_new  = {ch_new, bim_new};
  assign g_new   = tbp_pkg::sat_move(g_cur, s2_taken_q);

  // saturating totals
  assign branches_d = (branches_q == tbp_pkg::TOTAL_MAX) ? branches_q : branches_q + 32'd1;
  assign hits_d     = (ok && (hits_q != tbp_pkg::TOTAL_MAX)) ? hits_q + 32'd1 : hits_q;

  assign s2_valid_d  = pop || (s2_valid_q && !s2_fire);
  assign out_valid_d = s2_fire || (out_valid_q && !out_ready_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_bc_q    <= 1'b0;
      fwd_g_q     <= 1'b0;
      hits_q      <= '0;
      branches_q  <= '0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      if (pop) begin
        fwd_bc_q <= s2_fire && (s2_bi_q == in_bi);
        fwd_g_q  <= s2_fire && (s2_gi_q == in_gi);
      end
      if (s2_fire) begin
        hits_q     <= hits_d;
        branches_q <= branches_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop) begin
      s2_bi_q       <= in_bi;
      s2_gi_q       <= in_gi;
      s2_taken_q    <= in_taken;
      fwd_bc_data_q <= bc_new;
      fwd_g_data_q  <= g_new;
    end
    if (s2_fire) begin
      out_q.predicted_taken <= pred;
      out_q.correct         <= ok;
      out_q.used_bimodal    <= use_bi;
      out_q.correct_count   <= hits_d;
      out_q.branch_count    <= branches_d;
    end
  end

  assign pop_o       = pop;
  assign clearing_o  = (state_q == ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  // checks
  `ASSERT_ALWAYS(a_no_pop_clearing, clk_i, (state_q == ST_CLEAR) |-> !pop,
                 "word taken while tables are being cleared")
  `ASSERT_CHK(a_branch_step, clk_i, rst_ni,
              (s2_fire && (branches_q != tbp_pkg::TOTAL_MAX)) |=>
                (branches_q == $past(branches_q) + 32'd1),
              "branch total did not advance by one")
  `ASSERT_CHK(a_hits_le_branches, clk_i, rst_ni, hits_q <= branches_q,
              "correct total above branch total")
  `ASSERT_CHK(a_out_from_exec, clk_i, rst_ni, $rose(out_valid_q) |-> $past(s2_fire),
              "result shown without an execute step")

endmodule

// File: dv/tournament_branch_predictor_test.sv
// Self-checking bench for the tournament branch predictor: drives resolved
// branch words, predicts every result word and checks it field by field.
// Depends on tbp_pkg and the tournament_branch_predictor RTL only.
`timescale 1ns / 1ps

module tournament_branch_predictor_test;

  localparam int unsigned TABLE_N     = 2048;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned LONG_HOLD   = 80;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [tbp_pkg::HIST_W-1:0]   cfg_wdata_i   = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  // [31:0] pc, [32] taken, [39:33] zero
  logic [39:0]                  s_axis_tdata  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  // [0] predicted_taken, [1] correct, [2] used_bimodal,
  // [34:3] correct_count, [66:35] branch_count, [71:67] zero
  logic [71:0]                  m_axis_tdata;

  tournament_branch_predictor #(
    .TABLE_ENTRIES(TABLE_N)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow predictor plus queue of result words still owed by the block
  class branch_scoreboard;
    logic [tbp_pkg::CTR_W-1:0]   gs_ctr [TABLE_N];
    logic [tbp_pkg::CTR_W-1:0]   bm_ctr [TABLE_N];
    logic [tbp_pkg::CTR_W-1:0]   sel_ctr[TABLE_N];
    logic [tbp_pkg::HIST_W-1:0]  ghist;
    logic [tbp_pkg::HIST_W-1:0]  hmask;
    logic [tbp_pkg::TOTAL_W-1:0] hits;
    logic [tbp_pkg::TOTAL_W-1:0] branches;
    tbp_pkg::result_t            owed_q[$];
    int                          errors;

    function new();
      foreach (gs_ctr[i]) begin
        gs_ctr[i]  = 2'd3;
        bm_ctr[i]  = 2'd3;
        sel_ctr[i] = 2'd0;
      end
      ghist    = '0;
      hmask    = '1;
      hits     = '0;
      branches = '0;
      errors   = 0;
    endfunction

    function void set_mask(logic [tbp_pkg::HIST_W-1:0] m);
      hmask = m;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Note an accepted branch: work out its result word and train the tables
    function void note_branch(logic [tbp_pkg::PC_W-1:0] pc, logic tk);
      int unsigned      bi, gi;
      logic             g_hit, b_hit, pick_bm, guess;
      tbp_pkg::result_t r;
      bi      = pc & (TABLE_N - 1);
      gi      = (bi ^ int'(ghist & hmask)) & (TABLE_N - 1);
      pick_bm = sel_ctr[bi][1];
      guess   = pick_bm ? bm_ctr[bi][1] : gs_ctr[gi][1];
      g_hit   = (gs_ctr[gi][1] == tk);
      b_hit   = (bm_ctr[bi][1] == tk);
      // selector leans toward the table that alone got it right
      if (g_hit && !b_hit && sel_ctr[bi] != 2'd0) sel_ctr[bi] = sel_ctr[bi] - 2'd1;
      if (b_hit && !g_hit && sel_ctr[bi] != 2'd3) sel_ctr[bi] = sel_ctr[bi] + 2'd1;
      if (tk) begin
        if (gs_ctr[gi] != 2'd3) gs_ctr[gi] = gs_ctr[gi] + 2'd1;
        if (bm_ctr[bi] != 2'd3) bm_ctr[bi] = bm_ctr[bi] + 2'd1;
      end else begin
        if (gs_ctr[gi] != 2'd0) gs_ctr[gi] = gs_ctr[gi] - 2'd1;
        if (bm_ctr[bi] != 2'd0) bm_ctr[bi] = bm_ctr[bi] - 2'd1;
      end
      ghist = {ghist[tbp_pkg::HIST_W-2:0], tk};
      if (branches != '1) branches = branches + 1;
      if (guess == tk && hits != '1) hits = hits + 1;
      r.predicted_taken = guess;
      r.correct         = (guess == tk);
      r.used_bimodal    = pick_bm;
      r.correct_count   = hits;
      r.branch_count    = branches;
      owed_q.push_back(r);
    endfunction

    // Compare one result word against the oldest owed one
    function void check_result(logic [71:0] w);
      tbp_pkg::result_t e;
      if (owed_q.size() == 0) begin
        $error("result word with nothing owed: %h", w);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (w[0] !== e.predicted_taken) begin
        $error("predicted_taken: expected %0d, got %0d", e.predicted_taken, w[0]);
        errors++;
      end
      if (w[1] !== e.correct) begin
        $error("correct: expected %0d, got %0d", e.correct, w[1]);
        errors++;
      end
      if (w[2] !== e.used_bimodal) begin
        $error("used_bimodal: expected %0d, got %0d", e.used_bimodal, w[2]);
        errors++;
      end
      if (w[34:3] !== e.correct_count) begin
        $error("correct_count: expected %0d, got %0d", e.correct_count, w[34:3]);
        errors++;
      end
      if (w[66:35] !== e.branch_count) begin
        $error("branch_count: expected %0d, got %0d", e.branch_count, w[66:35]);
        errors++;
      end
    endfunction
  endclass

  branch_scoreboard sb = new();

  logic        src_idle_on  = 1'b0;
  logic        sink_idle_on = 1'b0;
  int unsigned hold_req     = 0;

  // Clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result side: check accepted words, then pick tready for the next edge
  initial begin
    int unsigned hold_left, stall_left;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one branch word and wait for it to be taken
  task automatic send_branch(input logic [tbp_pkg::PC_W-1:0] pc, input logic tk);
    int unsigned gap;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, tk, pc};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_branch(pc, tk);
  endtask

  // Drop tvalid and wait until every owed word is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_mask(input logic [tbp_pkg::HIST_W-1:0] m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_mask(m);
  endtask

  // Mostly a small set of hot branches with typical behaviour, some noise
  task automatic run_random(input int n_items, input logic idling);
    logic [tbp_pkg::HIST_W-1:0] hot_idx[16];
    int unsigned                kind[16];
    logic                       flip[16];
    int unsigned                k;
    logic [tbp_pkg::PC_W-1:0]   pc;
    logic                       tk;
    foreach (hot_idx[i]) begin
      hot_idx[i] = $urandom_range(0, TABLE_N - 1);
      kind[i]    = $urandom_range(0, 3);
      flip[i]    = $urandom_range(0, 1);
    end
    hot_idx[0] = '0;
    hot_idx[1] = '1;
    for (int n = 0; n < n_items; n++) begin
      if (n % 60 == 0) begin
        src_idle_on  = idling && ($urandom_range(0, 2) != 0);
        sink_idle_on = idling && ($urandom_range(0, 2) != 0);
      end
      pc = $urandom();
      if ($urandom_range(0, 4) != 0) begin
        k = $urandom_range(0, 15);
        pc[tbp_pkg::HIST_W-1:0] = hot_idx[k];
        case (kind[k])
          0: tk = ($urandom_range(0, 9) != 0);   // mostly taken
          1: tk = ($urandom_range(0, 9) == 0);   // mostly not taken
          2: begin                               // alternating, history helps
            flip[k] = ~flip[k];
            tk = flip[k];
          end
          default: tk = $urandom_range(0, 1);
        endcase
      end else begin
        tk = $urandom_range(0, 1);
      end
      send_branch(pc, tk);
    end
    drain();
  endtask

  // Main sequence
  initial begin
    logic [tbp_pkg::PC_W-1:0] pc;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // mask may be written while the tables are being cleared
    write_mask('1);

    // directed: address extremes and both outcomes
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hAAAA_AAAA, 1'b1);
    send_branch(32'h5555_5555, 1'b0);
    // shift four ones into the history so later gshare lookups hit fresh entries
    send_branch(32'h0000_0011, 1'b1);
    send_branch(32'h8000_0022, 1'b1);
    send_branch(32'h4000_0033, 1'b1);
    send_branch(32'h2000_0044, 1'b1);
    // one branch turning not-taken: bimodal alone right, selector moves up
    for (int i = 0; i < 8; i++) begin
      pc = $urandom();
      pc[tbp_pkg::HIST_W-1:0] = 11'h777;
      send_branch(pc, 1'b0);
    end
    // same branch flips back: gshare alone right at first, bimodal wrong until it recovers
    for (int i = 0; i < 4; i++) begin
      pc = $urandom();
      pc[tbp_pkg::HIST_W-1:0] = 11'h777;
      send_branch(pc, 1'b1);
    end
    drain();

    // no history in the gshare index; receiver holds off to fill the block
    write_mask('0);
    hold_req = LONG_HOLD;
    run_random(300, 1'b1);

    write_mask(tbp_pkg::HIST_W'($urandom_range(1, 2046)));
    run_random(300, 1'b1);

    write_mask(11'h001);
    run_random(300, 1'b1);

    // full history, back to back to finish
    write_mask('1);
    run_random(450, 1'b0);

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: tournament_branch_predictor.f
+incdir+design
design/tbp_pkg.sv
design/tbp_ram.sv
design/tbp_queue.sv
design/tbp_front.sv
design/tbp_back.sv
design/tournament_branch_predictor.sv
dv/tournament_branch_predictor_test.sv
